### rtl/owm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_pkg
// Shared types and constants of the one-wire bus master: item kinds, timing
// register indexes and the classified command that crosses the queue.
// ---------------------------------------------------------------------------
package owm_pkg;

   // widths fixed by the item and register formats
   localparam int KIND_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int TIME_W  = 10;
   localparam int INDEX_W = 3;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESET = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

   // timing register indexes
   localparam logic [INDEX_W-1:0] REG_RESET_LOW   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_RESET_WAIT  = 3'd1;
   localparam logic [INDEX_W-1:0] REG_SLOT_LOW    = 3'd2;
   localparam logic [INDEX_W-1:0] REG_WRITE_HOLD  = 3'd3;
   localparam logic [INDEX_W-1:0] REG_RECOVERY    = 3'd4;
   localparam logic [INDEX_W-1:0] REG_READ_SAMPLE = 3'd5;
   localparam logic [INDEX_W-1:0] REG_READ_TAIL   = 3'd6;

   // timing register reset values
   localparam logic [TIME_W-1:0] RESET_LOW_DEF   = 10'd400;
   localparam logic [TIME_W-1:0] RESET_WAIT_DEF  = 10'd400;
   localparam logic [TIME_W-1:0] SLOT_LOW_DEF    = 10'd2;
   localparam logic [TIME_W-1:0] WRITE_HOLD_DEF  = 10'd60;
   localparam logic [TIME_W-1:0] RECOVERY_DEF    = 10'd2;
   localparam logic [TIME_W-1:0] READ_SAMPLE_DEF = 10'd6;
   localparam logic [TIME_W-1:0] READ_TAIL_DEF   = 10'd80;

   // classified item as held in the queue
   typedef struct packed {
      logic              is_tick;
      logic              is_reset;
      logic              is_read;
      logic [BYTE_W-1:0] operand;
      logic              level;
   } cmd_type;

endpackage
`default_nettype wire

### rtl/owm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_front
// Input side: accepts items when the queue has room and classifies them
// into tick, reset, write or read with the preset shift operand.
// ---------------------------------------------------------------------------
module owm_front (
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [owm_pkg::KIND_W-1:0] req_kind,
   input  wire logic [owm_pkg::BYTE_W-1:0] req_write_byte,
   input  wire logic                       req_bus_level,
   input  wire logic                       queue_full,
   output logic                            push,
   output owm_pkg::cmd_type                push_cmd
);
   import owm_pkg::*;

   // stall only on a full queue
   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

   // classify the item
   always_comb begin
      push_cmd          = '0;
      push_cmd.level    = req_bus_level;
      push_cmd.is_tick  = (req_kind == KIND_TICK);
      push_cmd.is_reset = (req_kind == KIND_RESET);
      push_cmd.is_read  = (req_kind == KIND_READ);
      // a read shifts in from zero, a write shifts out the byte
      push_cmd.operand  = (req_kind == KIND_WRITE) ? req_write_byte : '0;
   end

endmodule
`default_nettype wire

### rtl/owm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_queue
// Short first-in first-out queue of classified items between the input
// side and the bus engine.
// ---------------------------------------------------------------------------
module owm_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire owm_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output logic                  pop_valid,
   output owm_pkg::cmd_type      pop_cmd
);
   import owm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign full      = (count_ff == FULL_COUNT);
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

### rtl/owm_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_engine
// Bus engine: timing registers, slot sequencer and the result register.
// Takes one item from the queue whenever the result register is free or being taken.
// ---------------------------------------------------------------------------
module owm_engine (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_en,
   input  wire logic [owm_pkg::INDEX_W-1:0] csr_index,
   input  wire logic [owm_pkg::TIME_W-1:0]  csr_wdata,
   input  wire logic                        pop_valid,
   input  wire owm_pkg::cmd_type            pop_cmd,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_drive_low,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic [owm_pkg::BYTE_W-1:0]       rsp_read_byte,
   output logic                             rsp_rejected
);
   import owm_pkg::*;

   // sequencer phases
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_RST_LOW  = 3'd1;
   localparam logic [2:0] PH_RST_WAIT = 3'd2;
   localparam logic [2:0] PH_SLOT_LOW = 3'd3;
   localparam logic [2:0] PH_WR_HOLD  = 3'd4;
   localparam logic [2:0] PH_WR_REC   = 3'd5;
   localparam logic [2:0] PH_RD_WAIT  = 3'd6;
   localparam logic [2:0] PH_RD_TAIL  = 3'd7;

   logic [TIME_W-1:0] reset_low_ff, reset_wait_ff, slot_low_ff, write_hold_ff;
   logic [TIME_W-1:0] recovery_ff, read_sample_ff, read_tail_ff;

   logic [2:0]        phase_ff,     phase_in;
   logic [TIME_W-1:0] time_left_ff, time_left_in;
   logic [2:0]        bit_index_ff, bit_index_in;
   logic              op_is_read_ff, op_is_read_in;
   logic [BYTE_W-1:0] shift_ff,     shift_in;
   logic              line_ff,      line_in;
   logic [BYTE_W-1:0] last_read_ff, last_read_in;
   logic              valid_ff,     valid_in;
   logic              done_ff,      done_in;
   logic              rej_ff,       rej_in;
   logic              busy;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff   <= RESET_LOW_DEF;
         reset_wait_ff  <= RESET_WAIT_DEF;
         slot_low_ff    <= SLOT_LOW_DEF;
         write_hold_ff  <= WRITE_HOLD_DEF;
         recovery_ff    <= RECOVERY_DEF;
         read_sample_ff <= READ_SAMPLE_DEF;
         read_tail_ff   <= READ_TAIL_DEF;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_RESET_LOW:   reset_low_ff   <= csr_wdata;
            REG_RESET_WAIT:  reset_wait_ff  <= csr_wdata;
            REG_SLOT_LOW:    slot_low_ff    <= csr_wdata;
            REG_WRITE_HOLD:  write_hold_ff  <= csr_wdata;
            REG_RECOVERY:    recovery_ff    <= csr_wdata;
            REG_READ_SAMPLE: read_sample_ff <= csr_wdata;
            REG_READ_TAIL:   read_tail_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // take the next item when the result register is free or being taken
   assign busy = (phase_ff != PH_IDLE);
   assign pop  = pop_valid & (~valid_ff | ~rsp_stall);

   // sequencer next state
   always_comb begin
      phase_in      = phase_ff;
      time_left_in  = time_left_ff;
      bit_index_in  = bit_index_ff;
      op_is_read_in = op_is_read_ff;
      shift_in      = shift_ff;
      line_in       = line_ff;
      last_read_in  = last_read_ff;
      valid_in      = valid_ff & rsp_stall;
      done_in       = done_ff;
      rej_in        = rej_ff;
      if (pop) begin
         valid_in = 1'b1;
         done_in  = 1'b0;
         rej_in   = 1'b0;
         if (!pop_cmd.is_tick) begin
            if (busy) begin
               // command while busy is dropped and flagged
               rej_in = 1'b1;
            end else if (pop_cmd.is_reset) begin
               phase_in     = PH_RST_LOW;
               time_left_in = reset_low_ff;
               line_in      = 1'b1;
            end else begin
               op_is_read_in = pop_cmd.is_read;
               shift_in      = pop_cmd.operand;
               bit_index_in  = '0;
               phase_in      = PH_SLOT_LOW;
               time_left_in  = slot_low_ff;
               line_in       = 1'b1;
            end
         end else if (busy) begin
            if (time_left_ff > TIME_W'(1)) begin
               time_left_in = time_left_ff - 1'b1;
            end else begin
               case (phase_ff)
                  PH_RST_LOW: begin
                     phase_in     = PH_RST_WAIT;
                     time_left_in = reset_wait_ff;
                     line_in      = 1'b0;
                  end
                  PH_RST_WAIT: begin
                     phase_in     = PH_IDLE;
                     time_left_in = '0;
                     done_in      = 1'b1;
                  end
                  PH_SLOT_LOW: begin
                     if (op_is_read_ff) begin
                        phase_in     = PH_RD_WAIT;
                        time_left_in = read_sample_ff;
                        line_in      = 1'b0;
                     end else begin
                        // a one bit releases the line after the start pulse
                        if (shift_ff[0]) begin
                           line_in = 1'b0;
                        end
                        shift_in     = {1'b0, shift_ff[BYTE_W-1:1]};
                        phase_in     = PH_WR_HOLD;
                        time_left_in = write_hold_ff;
                     end
                  end
                  PH_WR_HOLD: begin
                     phase_in     = PH_WR_REC;
                     time_left_in = recovery_ff;
                     line_in      = 1'b0;
                  end
                  PH_RD_WAIT: begin
                     // sample the line, lsb first
                     shift_in     = {pop_cmd.level, shift_ff[BYTE_W-1:1]};
                     phase_in     = PH_RD_TAIL;
                     time_left_in = read_tail_ff;
                  end
                  PH_WR_REC, PH_RD_TAIL: begin
                     if (bit_index_ff == 3'd7) begin
                        if (op_is_read_ff) begin
                           last_read_in = shift_ff;
                        end
                        phase_in     = PH_IDLE;
                        time_left_in = '0;
                        bit_index_in = '0;
                        done_in      = 1'b1;
                     end else begin
                        bit_index_in = bit_index_ff + 1'b1;
                        phase_in     = PH_SLOT_LOW;
                        time_left_in = slot_low_ff;
                        line_in      = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         time_left_ff  <= '0;
         bit_index_ff  <= '0;
         op_is_read_ff <= 1'b0;
         shift_ff      <= '0;
         line_ff       <= 1'b0;
         last_read_ff  <= '0;
         valid_ff      <= 1'b0;
         done_ff       <= 1'b0;
         rej_ff        <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         time_left_ff  <= time_left_in;
         bit_index_ff  <= bit_index_in;
         op_is_read_ff <= op_is_read_in;
         shift_ff      <= shift_in;
         line_ff       <= line_in;
         last_read_ff  <= last_read_in;
         valid_ff      <= valid_in;
         done_ff       <= done_in;
         rej_ff        <= rej_in;
      end
   end

   // the state only moves when an item is taken, so it doubles as the result
   assign rsp_valid     = valid_ff;
   assign rsp_drive_low = line_ff;
   assign rsp_busy_res  = busy;
   assign rsp_done_res  = done_ff;
   assign rsp_read_byte = last_read_ff;
   assign rsp_rejected  = rej_ff;

endmodule
`default_nettype wire

### rtl/one_wire_bus_master.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master: reset pulse, byte write and byte read, timed by
// microsecond tick items.
// ---------------------------------------------------------------------------
// Every item (a microsecond tick or a command) gives exactly one result item
// that shows the line drive, busy, done, the last read byte and whether a
// command was rejected. The block takes one item per clock while the queue
// is not full; an item is written into the queue when accepted and moves
// into the engine's result register when the engine takes it, and its result
// then stays on the rsp_ ports until it is taken. Throughput
// is set by the engine, which retires one queued item per clock whenever its
// result register is empty or being taken; a stalled result side fills the
// QUEUE_DEPTH-entry queue before req_stall rises. Timing registers may only
// be written while no item is in flight.
module one_wire_bus_master #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [owm_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [owm_pkg::BYTE_W-1:0]  req_write_byte,
   input  wire logic                        req_bus_level,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_drive_low,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic [owm_pkg::BYTE_W-1:0]       rsp_read_byte,
   output logic                             rsp_rejected,
   input  wire logic                        csr_write_en,
   input  wire logic [owm_pkg::INDEX_W-1:0] csr_index,
   input  wire logic [owm_pkg::TIME_W-1:0]  csr_wdata
);
   import owm_pkg::*;

   logic    queue_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    pop_valid;
   cmd_type pop_cmd;

   // accept and classify
   owm_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_write_byte (req_write_byte),
      .req_bus_level  (req_bus_level),
      .queue_full     (queue_full),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // decoupling queue
   owm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   // bus sequencing and results
   owm_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .pop_valid     (pop_valid),
      .pop_cmd       (pop_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_drive_low (rsp_drive_low),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_read_byte (rsp_read_byte),
      .rsp_rejected  (rsp_rejected)
   );

endmodule
`default_nettype wire

### rtl/owm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_checker
// Port-level checks of the one-wire bus master, bound to the top level.
// ---------------------------------------------------------------------------
module owm_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic                        rsp_drive_low,
   input wire logic                        rsp_busy_res,
   input wire logic                        rsp_done_res,
   input wire logic [owm_pkg::BYTE_W-1:0]  rsp_read_byte,
   input wire logic                        rsp_rejected
);

   // a stalled result item holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive_low)
         && $stable(rsp_busy_res) && $stable(rsp_done_res)
         && $stable(rsp_read_byte) && $stable(rsp_rejected))
      else $error("result item changed while stalled");

   // a finished command leaves the master idle
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_rejected)
      else $error("done reported while still busy or rejecting");

   // rejection only happens while a command is running
   a_rej_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res)
      else $error("command rejected while idle");

   // an idle master never drives the line
   a_idle_release : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> !rsp_drive_low)
      else $error("line driven while idle");

   // no result straight out of reset
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item right after reset");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_drive_low (rsp_drive_low),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_done_res  (rsp_done_res),
   .rsp_read_byte (rsp_read_byte),
   .rsp_rejected  (rsp_rejected)
);
`default_nettype wire
